>>> hdl/rtbf_pkg.sv
package rtbf_pkg;

  // field and register widths
  localparam int unsigned PixelW  = 32;
  localparam int unsigned AlphaLo = 24;
  localparam int unsigned RowW    = 14;
  localparam int unsigned CntW    = 13;
  localparam int unsigned ApbW    = 32;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned OutW    = 32;

  localparam int unsigned MaxWidthDef = 4096;

  localparam logic [CntW-1:0] CntAllOnes = '1;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegRowWidth = 2'd0,
    RegStartRow = 2'd1,
    RegStopRow  = 2'd2,
    RegNone     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CntW-1:0] row_width;
    logic [RowW-1:0] start_row;
    logic [RowW-1:0] stop_row;
  } cfg_t;

endpackage

>>> hdl/row_transition_break_finder.sv
// Row transition break finder. Stream ARGB pixels of candidate rows, highest
// row (start_row) first, each row left to right over row_width pixels; the
// block counts colour changes per row and, after the last pixel of the stop
// row (or of row 0), returns one result: the midpoint of the run of adjacent
// rows that share the lowest change count, plus that count. A search starts
// with the first pixel after the previous result. Throughput is one pixel per
// cycle; a pixel passes through the input register, then the per-pixel
// update into the result register. The pixel pipe holds only when a
// search-ending pixel meets a result not yet taken. Registers are
// written over the APB-style port and are read live, so write them between
// searches.
module row_transition_break_finder #(
  parameter int unsigned MAX_WIDTH = rtbf_pkg::MaxWidthDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel requests
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rtbf_pkg::PixelW-1:0] in_tdata,    // [31:0] pixel
  // result requests
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rtbf_pkg::OutW-1:0]   out_tdata,   // [13:0] break_row, [26:14] min_changes
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rtbf_pkg::AddrW-1:0]  cfg_paddr,
  input  logic [rtbf_pkg::ApbW-1:0]   cfg_pwdata,
  output logic [rtbf_pkg::ApbW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RowW = rtbf_pkg::RowW;
  localparam int unsigned CntW = rtbf_pkg::CntW;

  rtbf_pkg::cfg_t  cfg;
  logic [ColW-1:0] eff_width;

  rtbf_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .cfg      (cfg),
    .eff_width(eff_width)
  );

  // input register
  logic                        s1_vld_r;
  logic [rtbf_pkg::PixelW-1:0] s1_pix_r;
  logic                        s1_adv;

  // search state
  logic                        active_r;
  logic [ColW-1:0]             col_r;
  logic [RowW-1:0]             row_r;
  logic [rtbf_pkg::PixelW-1:0] color_r;
  logic                        prev_t_r;
  logic [CntW-1:0]             rc_r;
  logic [CntW-1:0]             best_c_r;
  logic [RowW-1:0]             top_r;
  logic [RowW-1:0]             bot_r;
  logic                        open_r;

  // result register
  logic                        out_vld_r;
  logic [rtbf_pkg::OutW-1:0]   out_data_r;

  // state as seen by this pixel: a fresh search starts from clean values
  logic                        start;
  logic [ColW-1:0]             col;
  logic [RowW-1:0]             row;
  logic [rtbf_pkg::PixelW-1:0] color;
  logic                        prev_t;
  logic [CntW-1:0]             rc;
  logic [CntW-1:0]             best_c;
  logic [RowW-1:0]             top;
  logic [RowW-1:0]             bot;
  logic                        open;

  logic                        cur_t;
  logic                        chg;
  logic [CntW-1:0]             rc_new;
  logic [rtbf_pkg::PixelW-1:0] color_new;
  logic [ColW-1:0]             col_new;
  logic                        row_end;
  logic                        search_end;
  logic [CntW-1:0]             best_c_new;
  logic [RowW-1:0]             top_new;
  logic [RowW-1:0]             bot_new;
  logic                        open_new;
  logic [RowW-1:0]             mid;

  always_comb begin
    start  = !active_r;
    col    = start ? '0 : col_r;
    row    = start ? cfg.start_row : row_r;
    color  = start ? '0 : color_r;
    prev_t = start ? 1'b0 : prev_t_r;
    rc     = start ? '0 : rc_r;
    best_c = start ? rtbf_pkg::CntAllOnes : best_c_r;
    top    = start ? '0 : top_r;
    bot    = start ? '0 : bot_r;
    open   = start ? 1'b0 : open_r;
  end

  // colour change: differs from running colour, not transparent to transparent
  always_comb begin
    cur_t     = (s1_pix_r[rtbf_pkg::PixelW-1:rtbf_pkg::AlphaLo] == '0);
    chg       = (s1_pix_r != color) && !(cur_t && prev_t);
    color_new = chg ? s1_pix_r : color;
    rc_new    = (chg && (rc != rtbf_pkg::CntAllOnes)) ? rc + CntW'(1) : rc;
    col_new   = col + ColW'(1);
    row_end   = (col_new >= eff_width);
  end

  // row close: new minimum opens a run, an equal count directly below extends it
  always_comb begin
    best_c_new = best_c;
    top_new    = top;
    bot_new    = bot;
    open_new   = open;
    if (row_end) begin
      priority if (rc_new < best_c) begin
        best_c_new = rc_new;
        top_new    = row;
        bot_new    = row;
        open_new   = 1'b1;
      end else if (rc_new == best_c) begin
        if (open && (bot != '0) && (row == bot - RowW'(1))) begin
          bot_new = row;
        end else begin
          open_new = 1'b0;
        end
      end else begin
        open_new = 1'b0;
      end
    end
    search_end = row_end && ((row <= cfg.stop_row) || (row == '0));
    mid        = bot_new + ((top_new - bot_new) >> 1);
  end

  // hold the pixel only when it would overwrite a result not yet taken
  assign s1_adv    = s1_vld_r && !(search_end && out_vld_r && !out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pix_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      open_r   <= 1'b0;
    end else if (s1_adv) begin
      active_r <= !search_end;
      open_r   <= search_end ? 1'b0 : open_new;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      col_r    <= row_end ? '0 : col_new;
      color_r  <= row_end ? '0 : color_new;
      rc_r     <= row_end ? '0 : rc_new;
      prev_t_r <= cur_t;
      row_r    <= row_end ? row - RowW'(1) : row;
      best_c_r <= best_c_new;
      top_r    <= top_new;
      bot_r    <= bot_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && search_end) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && search_end) begin
      out_data_r <= rtbf_pkg::OutW'({best_c_new, mid});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/rtbf_cfg_regs.sv
module rtbf_cfg_regs #(
  parameter int unsigned MAX_WIDTH = rtbf_pkg::MaxWidthDef,
  localparam int unsigned ColW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rtbf_pkg::AddrW-1:0] paddr,
  input  logic [rtbf_pkg::ApbW-1:0]  pwdata,
  output logic [rtbf_pkg::ApbW-1:0]  prdata,
  output logic                       pready,
  output rtbf_pkg::cfg_t             cfg,
  output logic [ColW-1:0]            eff_width
);

  rtbf_pkg::cfg_t   cfg_r;
  rtbf_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = rtbf_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_width <= rtbf_pkg::CntW'(1);
      cfg_r.start_row <= '0;
      cfg_r.stop_row  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        rtbf_pkg::RegRowWidth: cfg_r.row_width <= pwdata[rtbf_pkg::CntW-1:0];
        rtbf_pkg::RegStartRow: cfg_r.start_row <= pwdata[rtbf_pkg::RowW-1:0];
        rtbf_pkg::RegStopRow:  cfg_r.stop_row  <= pwdata[rtbf_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rtbf_pkg::RegRowWidth: prdata = rtbf_pkg::ApbW'(cfg_r.row_width);
      rtbf_pkg::RegStartRow: prdata = rtbf_pkg::ApbW'(cfg_r.start_row);
      rtbf_pkg::RegStopRow:  prdata = rtbf_pkg::ApbW'(cfg_r.stop_row);
      default:               prdata = '0;
    endcase
  end

  // zero width counts as one, saturate at MAX_WIDTH
  always_comb begin
    if (cfg_r.row_width == '0) begin
      eff_width = ColW'(1);
    end else if (32'(cfg_r.row_width) > 32'(MAX_WIDTH)) begin
      eff_width = ColW'(MAX_WIDTH);
    end else begin
      eff_width = ColW'(cfg_r.row_width);
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/rtbf_checker.sv
module rtbf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [rtbf_pkg::OutW-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // padding above min_changes stays zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[rtbf_pkg::OutW-1:rtbf_pkg::RowW+rtbf_pkg::CntW] == '0)
    else $error("result padding not zero");

  // an empty result register never back-pressures pixels
  a_in_ready: assert property (@(posedge clk)
    !out_tvalid |-> in_tready)
    else $error("pixel held with no result pending");

  // reset drops any pending result
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind row_transition_break_finder rtbf_checker u_rtbf_checker (.*);
